/* rtl/core/spef_pkg.sv */
// Shared types, constants and helpers for the stereo peak envelope follower.
`timescale 1ns / 1ps

package spef_pkg;

  // Widths of the sample containers, the magnitudes and the reported levels.
  localparam int SAMPLE_W   = 32;
  localparam int MAG_W      = 24;
  localparam int OUT_W      = 24;
  localparam int CALC_W     = 32;
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  localparam int NORM_SHIFT = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKING_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_IS_16BIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_SHIFT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_SHIFT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_DECAY_SHIFT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DECAY_SHIFT = 3'd5;

  // Reset values of the shift registers.
  localparam logic [SHIFT_W-1:0] RISE_SHIFT_RST       = 5'd12;
  localparam logic [SHIFT_W-1:0] FALL_SHIFT_RST       = 5'd16;
  localparam logic [SHIFT_W-1:0] FAST_DECAY_SHIFT_RST = 5'd12;
  localparam logic [SHIFT_W-1:0] SLOW_DECAY_SHIFT_RST = 5'd20;

  // Configuration as seen by both update stages.
  typedef struct packed {
    logic               tracking_enable;
    logic               sample_is_16bit;
    logic [SHIFT_W-1:0] rise_shift;
    logic [SHIFT_W-1:0] fall_shift;
    logic [SHIFT_W-1:0] fast_decay_shift;
    logic [SHIFT_W-1:0] slow_decay_shift;
  } cfg_t;

  // Move a level down toward a lower target by a shifted fraction of the gap,
  // landing on the target when the step would pass zero.
  function automatic logic [CALC_W-1:0] fall_toward(
    input logic [CALC_W-1:0]  high,
    input logic [CALC_W-1:0]  low,
    input logic [SHIFT_W-1:0] shift
  );
    logic [CALC_W-1:0] delta;
    delta = (high - low) >> shift;
    return (high > delta) ? (high - delta) : low;
  endfunction

endpackage

/* rtl/core/spef_if.sv */
// Valid/ready channel interfaces for sample pairs and level results.
`timescale 1ns / 1ps

interface spef_pair_if;
  logic                                valid;
  logic                                ready;
  logic signed [spef_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [spef_pkg::SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface spef_level_if;
  logic                         valid;
  logic                         ready;
  logic [spef_pkg::OUT_W-1:0]   left_short_level;
  logic [spef_pkg::OUT_W-1:0]   left_long_level;
  logic [spef_pkg::OUT_W-1:0]   right_short_level;
  logic [spef_pkg::OUT_W-1:0]   right_long_level;

  modport source (output valid, output left_short_level, output left_long_level,
                  output right_short_level, output right_long_level, input ready);
  modport sink   (input valid, input left_short_level, input left_long_level,
                  input right_short_level, input right_long_level, output ready);
endinterface

/* rtl/core/spef_short.sv */
// Input register, sample normalisation and short peak level update stage.
`timescale 1ns / 1ps

module spef_short #(
  parameter int LEVEL_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  spef_pkg::cfg_t               cfg,
  spef_pair_if.sink                    in_pair,
  output logic                         s_valid,
  input  logic                         s_ready,
  output logic [1:0][LEVEL_BITS-1:0]   s_level
);
  import spef_pkg::*;

  localparam logic [CALC_W:0] LEVEL_MAX = (33'd1 << LEVEL_BITS) - 33'd1;

  logic                              in_valid;
  logic [1:0][SAMPLE_W-1:0]          in_raw;
  logic [1:0][LEVEL_BITS-1:0]        short_level;
  logic [1:0][LEVEL_BITS-1:0]        short_level_next;
  logic [1:0][LEVEL_BITS-1:0]        mag;
  logic                              stage_ready;
  logic                              move;

  // Magnitude of one container sample, 24 bits wide.
  function automatic logic [MAG_W-1:0] magnitude(
    input logic [SAMPLE_W-1:0] raw,
    input logic                is16
  );
    logic [15:0]      h;
    logic [15:0]      m16;
    logic [MAG_W-1:0] v;
    logic [MAG_W-1:0] m24;
    h   = raw[SAMPLE_W-1 -: 16];
    m16 = h[15] ? (~h + 16'd1) : h;
    v   = raw[SAMPLE_W-1 -: MAG_W];
    m24 = v[MAG_W-1] ? (~v + 24'd1) : v;
    return is16 ? {m16, 8'd0} : m24;
  endfunction

  // Handshake: the input register refills whenever its request moves on.
  assign stage_ready   = !s_valid || s_ready;
  assign in_pair.ready = !in_valid || stage_ready;
  assign move          = in_valid && stage_ready;

  // Normalise, saturate to the level width and update the short levels.
  always_comb begin
    logic [CALC_W:0]   m_ext;
    logic [CALC_W-1:0] s32;
    logic [CALC_W-1:0] m32;
    logic [CALC_W-1:0] upd;
    for (int ch = 0; ch < 2; ch++) begin
      m_ext   = 33'(magnitude(in_raw[ch], cfg.sample_is_16bit));
      mag[ch] = (m_ext > LEVEL_MAX) ? LEVEL_MAX[LEVEL_BITS-1:0] : m_ext[LEVEL_BITS-1:0];
      s32     = 32'(short_level[ch]);
      m32     = 32'(mag[ch]);
      if (m32 > s32) begin
        upd = s32 + ((m32 - s32) >> cfg.rise_shift);
      end else begin
        upd = fall_toward(s32, m32, cfg.fall_shift);
      end
      short_level_next[ch] = cfg.tracking_enable ? LEVEL_BITS'(upd) : short_level[ch];
    end
  end

  // Input register, short level state and the register toward the long stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      s_valid     <= 1'b0;
      short_level <= '0;
    end else begin
      if (in_pair.ready) begin
        in_valid <= in_pair.valid;
      end
      if (stage_ready) begin
        s_valid <= in_valid;
      end
      if (move) begin
        short_level <= short_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pair.valid && in_pair.ready) begin
      in_raw[0] <= in_pair.left_sample;
      in_raw[1] <= in_pair.right_sample;
    end
    if (move) begin
      s_level <= short_level_next;
    end
  end

`ifndef ASSERT_OFF
  // With tracking off the short levels never move.
  assert property (@(posedge clk) disable iff (rst)
    (move && !cfg.tracking_enable) |=> $stable(short_level))
    else $error("short level changed while tracking is disabled");

  // A new left short level lies between the old left level and the magnitude.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && cfg.tracking_enable) |->
      ((short_level_next[0] >= mag[0] && short_level_next[0] <= short_level[0]) ||
       (short_level_next[0] <= mag[0] && short_level_next[0] >= short_level[0])))
    else $error("left short level left its bracket");

  // A request waiting for the long stage keeps its levels.
  assert property (@(posedge clk) disable iff (rst)
    (s_valid && !s_ready) |=> (s_valid && $stable(s_level)))
    else $error("stalled short level request was lost");
`endif

endmodule

/* rtl/core/spef_long.sv */
// Long level update stage and result register.
`timescale 1ns / 1ps

module spef_long #(
  parameter int LEVEL_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  spef_pkg::cfg_t               cfg,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [1:0][LEVEL_BITS-1:0]   s_level,
  spef_level_if.source                 out_level
);
  import spef_pkg::*;

  logic [1:0][LEVEL_BITS-1:0] long_level;
  logic [1:0][LEVEL_BITS-1:0] long_level_next;
  logic                       move;

  // The result register takes a new request whenever it is empty or being read.
  assign s_ready = !out_level.valid || out_level.ready;
  assign move    = s_valid && s_ready;

  // Long level: jump up to the short level, otherwise leak down fast or slow.
  always_comb begin
    logic [CALC_W-1:0] s32;
    logic [CALC_W-1:0] l32;
    logic [CALC_W-1:0] upd;
    for (int ch = 0; ch < 2; ch++) begin
      s32 = 32'(s_level[ch]);
      l32 = 32'(long_level[ch]);
      if (s32 > l32) begin
        upd = s32;
      end else if (s32 < (l32 >> 2)) begin
        upd = fall_toward(l32, s32, cfg.fast_decay_shift);
      end else begin
        upd = fall_toward(l32, s32, cfg.slow_decay_shift);
      end
      long_level_next[ch] = cfg.tracking_enable ? LEVEL_BITS'(upd) : long_level[ch];
    end
  end

  // Long level state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_level.valid <= 1'b0;
      long_level      <= '0;
    end else begin
      if (s_ready) begin
        out_level.valid <= s_valid;
      end
      if (move) begin
        long_level <= long_level_next;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (move) begin
      out_level.left_short_level  <= OUT_W'(s_level[0]);
      out_level.left_long_level   <= OUT_W'(long_level_next[0]);
      out_level.right_short_level <= OUT_W'(s_level[1]);
      out_level.right_long_level  <= OUT_W'(long_level_next[1]);
    end
  end

`ifndef ASSERT_OFF
  // While tracking, the long level never ends below the short level.
  assert property (@(posedge clk) disable iff (rst)
    (move && cfg.tracking_enable) |->
      (long_level_next[0] >= s_level[0] && long_level_next[1] >= s_level[1]))
    else $error("long level fell below short level");

  // With tracking off the long levels never move.
  assert property (@(posedge clk) disable iff (rst)
    (move && !cfg.tracking_enable) |=> $stable(long_level))
    else $error("long level changed while tracking is disabled");

  // The result register only empties through a completed request.
  assert property (@(posedge clk) disable iff (rst)
    (out_level.valid && !out_level.ready) |=> out_level.valid)
    else $error("result dropped without being taken");
`endif

endmodule

/* rtl/core/stereo_peak_envelope_follower.sv */
// Top level of the stereo peak envelope follower.
`timescale 1ns / 1ps

// Stereo peak envelope follower. Takes one stereo pair of 32-bit container
// samples per request and returns one request holding the short and long
// levels of both channels after that pair. A new pair is taken every clock
// cycle while the result side does not stall; a pair is taken into the
// input register, the short level stage then registers its levels and the
// long level stage then loads the result register. The rate is set by the
// two level updates, each of which feeds its own state register back. The
// configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no pair is in flight, as the block
// itself does not enforce this.
module stereo_peak_envelope_follower #(
  parameter int LEVEL_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  spef_pair_if.sink                         in_pair,
  spef_level_if.source                      out_level,
  input  logic                              cfg_we,
  input  logic [spef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spef_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spef_pkg::*;

  cfg_t                       cfg;
  logic                       s_valid;
  logic                       s_ready;
  logic [1:0][LEVEL_BITS-1:0] s_level;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tracking_enable  <= 1'b0;
      cfg.sample_is_16bit  <= 1'b0;
      cfg.rise_shift       <= RISE_SHIFT_RST;
      cfg.fall_shift       <= FALL_SHIFT_RST;
      cfg.fast_decay_shift <= FAST_DECAY_SHIFT_RST;
      cfg.slow_decay_shift <= SLOW_DECAY_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRACKING_ENABLE:  cfg.tracking_enable  <= cfg_data[0];
        CFG_SAMPLE_IS_16BIT:  cfg.sample_is_16bit  <= cfg_data[0];
        CFG_RISE_SHIFT:       cfg.rise_shift       <= cfg_data;
        CFG_FALL_SHIFT:       cfg.fall_shift       <= cfg_data;
        CFG_FAST_DECAY_SHIFT: cfg.fast_decay_shift <= cfg_data;
        CFG_SLOW_DECAY_SHIFT: cfg.slow_decay_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  // Short level stage.
  spef_short #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_short (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_pair (in_pair),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_level (s_level)
  );

  // Long level stage and result register.
  spef_long #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_long (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_level   (s_level),
    .out_level (out_level)
  );

endmodule
